### sv/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

  // Field widths of the request and response channels.
  localparam int unsigned CmdW    = 2;
  localparam int unsigned TaskW   = 3;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned LimitW  = 16;

  // Configuration port: one index bit selects one of the two registers.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Default size of the slot bank.
  localparam int unsigned NumTasksDefault = 8;

  // Reset values of the configuration registers.
  localparam logic [LimitW-1:0] PrescaleLimitReset = 16'h0F00;
  localparam logic [CodeW-1:0]  TimerCodeReset     = 8'd1;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_SCAN   = 2'd0;
  localparam logic [CmdW-1:0] CMD_SET    = 2'd1;
  localparam logic [CmdW-1:0] CMD_CREATE = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_PRESCALE_LIMIT = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_TIMER_CODE     = 1'b1;

  // Control broadcast from the top level to every slot cell.
  typedef struct packed {
    logic               scan;
    logic               tick;
    logic               set_event;
    logic               create;
    logic [CodeW-1:0]   timer_code;
    logic [CodeW-1:0]   event_code;
    logic [PeriodW-1:0] period;
  } ptd_cell_ctrl_t;

endpackage

### sv/ptd_ifs.sv
`timescale 1ns / 1ps

// Request channel: one command per request.
interface ptd_req_if import ptd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    cmd;
  logic [TaskW-1:0]   task_req;
  logic [CodeW-1:0]   event_code;
  logic [PeriodW-1:0] period;

  modport source (output valid, cmd, task_req, event_code, period, input ready);
  modport sink   (input valid, cmd, task_req, event_code, period, output ready);
endinterface

// Response channel: one result per request.
interface ptd_rsp_if import ptd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             run_valid;
  logic [TaskW-1:0] run_task;
  logic             tick_done;

  modport source (output valid, run_valid, run_task, tick_done, input ready);
  modport sink   (input valid, run_valid, run_task, tick_done, output ready);
endinterface

// Configuration write channel.
interface ptd_cfg_if import ptd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/ptd_cell.sv
`timescale 1ns / 1ps

module ptd_cell import ptd_pkg::*; #(
  parameter bit FirstCell = 1'b0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ptd_cell_ctrl_t ctrl_i,
  input  logic           sel_i,
  input  logic           token_i,
  output logic           token_o,
  output logic           hit_o
);

  logic               token_q, token_d;
  logic [CodeW-1:0]   pend_q, pend_d;
  logic [PeriodW-1:0] count_q, count_d;
  logic [PeriodW-1:0] reload_q, reload_d;

  // The scan token sits in this slot and an event is pending.
  assign hit_o   = ctrl_i.scan && token_q && (pend_q != '0);
  assign token_o = token_q;

  // Slot update: dispatch clears first, a tick in the same step may post again.
  always_comb begin
    token_d  = token_q;
    pend_d   = pend_q;
    count_d  = count_q;
    reload_d = reload_q;
    if (ctrl_i.scan) begin
      token_d = token_i;
      if (token_q) begin
        pend_d = '0;
      end
      if (ctrl_i.tick) begin
        if (count_q != '0) begin
          count_d = count_q - PeriodW'(1);
        end else if (reload_q != '0) begin
          count_d = reload_q;
          pend_d  = ctrl_i.timer_code;
        end
      end
    end else if (ctrl_i.set_event && sel_i) begin
      pend_d = ctrl_i.event_code;
    end else if (ctrl_i.create && sel_i) begin
      reload_d = ctrl_i.period;
      count_d  = ctrl_i.period;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q  <= FirstCell;
      pend_q   <= '0;
      count_q  <= '0;
      reload_q <= '0;
    end else begin
      token_q  <= token_d;
      pend_q   <= pend_d;
      count_q  <= count_d;
      reload_q <= reload_d;
    end
  end

endmodule

### sv/ptd_prescaler.sv
`timescale 1ns / 1ps

module ptd_prescaler import ptd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [LimitW-1:0] limit_i,
  output logic              tick_o
);

  logic [LimitW-1:0] count_q, count_d;
  logic [LimitW:0]   count_inc;

  // The count never exceeds 16'hFFFE, so the increment never carries out of LimitW bits.
  assign count_inc = {1'b0, count_q} + (LimitW+1)'(1);
  assign tick_o    = step_i && (count_inc >= {1'b0, limit_i});

  always_comb begin
    count_d = count_q;
    if (step_i) begin
      count_d = tick_o ? '0 : count_inc[LimitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // An expiry always restarts the count.
  a_tick_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_o |=> count_q == '0)
    else $error("prescaler did not restart after a tick");

endmodule

### sv/periodic_task_event_dispatcher.sv
`timescale 1ns / 1ps
// A request's result is registered and offered on the response channel in the next cycle.
// One request per cycle unless the response stalls; all slot cells update in parallel, a tick too.
// The response register frees as it is taken, so a new request can enter as a waiting result is taken.
// Reset: asynchronous, active low; clears all slots, the scan position and the prescaler,
// and loads the prescale limit 3840 and the timer event code 1.

module periodic_task_event_dispatcher import ptd_pkg::*; #(
  parameter int unsigned NUM_TASKS = NumTasksDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  ptd_req_if.sink   in_i,
  ptd_rsp_if.source out_o,
  ptd_cfg_if.sink   cfg_i
);

  logic              in_acc;
  logic              scan_step;
  logic              out_valid_q, out_valid_d;
  logic              run_valid_q;
  logic [TaskW-1:0]  run_task_q;
  logic              tick_done_q;
  logic              run_valid_d;
  logic [TaskW-1:0]  run_task_d;
  logic              tick;
  logic [LimitW-1:0] limit_q;
  logic [CodeW-1:0]  timer_code_q;
  ptd_cell_ctrl_t    ctrl;
  logic [NUM_TASKS-1:0] sel;
  logic [NUM_TASKS-1:0] token;
  logic [NUM_TASKS-1:0] hit;

  // Handshakes: the response register frees when its result is taken.
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // An accepted scan step advances the prescaler.
  assign scan_step = in_acc && (in_i.cmd == CMD_SCAN);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= PrescaleLimitReset;
      timer_code_q <= TimerCodeReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PRESCALE_LIMIT: limit_q      <= cfg_i.data[LimitW-1:0];
        REG_TIMER_CODE:     timer_code_q <= cfg_i.data[CodeW-1:0];
        default:            ;
      endcase
    end
  end

  // Command decode into the control broadcast.
  always_comb begin
    ctrl            = '0;
    ctrl.timer_code = timer_code_q;
    ctrl.event_code = in_i.event_code;
    ctrl.period     = in_i.period;
    ctrl.tick       = tick;
    if (in_acc) begin
      case (in_i.cmd)
        CMD_SCAN:   ctrl.scan      = 1'b1;
        CMD_SET:    ctrl.set_event = 1'b1;
        CMD_CREATE: ctrl.create    = 1'b1;
        default:    ;
      endcase
    end
  end

  ptd_prescaler u_prescaler (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (scan_step),
    .limit_i (limit_q),
    .tick_o  (tick)
  );

  // Ring of slot cells; the scan token moves one cell per scan step.
  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    if (i < (1 << TaskW)) begin : g_addr
      assign sel[i] = (in_i.task_req == TaskW'(i));
    end else begin : g_noaddr
      assign sel[i] = 1'b0;
    end

    ptd_cell #(
      .FirstCell (i == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .sel_i   (sel[i]),
      .token_i (token[(i + NUM_TASKS - 1) % NUM_TASKS]),
      .token_o (token[i]),
      .hit_o   (hit[i])
    );
  end

  // Dispatched slot number, low bits only.
  always_comb begin
    run_valid_d = |hit;
    run_task_d  = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (hit[i]) begin
        run_task_d = run_task_d | TaskW'(i);
      end
    end
  end

  // Response register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      run_valid_q <= run_valid_d;
      run_task_q  <= run_task_d;
      tick_done_q <= tick;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.run_valid = run_valid_q;
  assign out_o.run_task  = run_task_q;
  assign out_o.tick_done = tick_done_q;

  // Exactly one cell holds the scan token.
  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(token))
    else $error("scan token lost or duplicated");

  // At most one cell dispatches per step.
  a_hit_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one slot dispatched");

  // Commands other than a scan step never report a dispatch or a tick.
  a_nonscan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.cmd != CMD_SCAN) |=> !run_valid_q && !tick_done_q)
    else $error("non-scan command produced a dispatch or tick");

endmodule
